// ===== hw/rtl/owbm_pkg.sv =====
// Shared types, constants and helpers for the 1-Wire bus master.
// Used by every module of the block; depends on nothing else.
package owbm_pkg;

	localparam int TIMER_WIDTH = 10;
	localparam logic [16:0] TMAX_EXT = 17'((32'd1 << TIMER_WIDTH) - 32'd1);

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 10;

	localparam logic [CFG_AW-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SHORT_LOW     = 3'd3;
	localparam logic [CFG_AW-1:0] REG_WRITE_ZERO    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_WRITE_SLOT    = 3'd5;
	localparam logic [CFG_AW-1:0] REG_READ_WAIT     = 3'd6;
	localparam logic [CFG_AW-1:0] REG_READ_TAIL     = 3'd7;

	localparam logic [2:0] OP_IDLE  = 3'd0;
	localparam logic [2:0] OP_RESET = 3'd1;
	localparam logic [2:0] OP_WBIT  = 3'd2;
	localparam logic [2:0] OP_RBIT  = 3'd3;
	localparam logic [2:0] OP_WBYTE = 3'd4;
	localparam logic [2:0] OP_RBYTE = 3'd5;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;
	localparam logic [1:0] PH_TAIL = 2'd3;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_NOP  = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] req_type;
		logic [7:0] data;
		logic       bus_level;
	} item_t;

	typedef struct packed {
		logic       rejected;
		logic [7:0] result_value;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} result_t;

	// Phase length: zero counts as one tick, anything past the timer saturates.
	function automatic logic [TIMER_WIDTH-1:0] clamp_len(input logic [16:0] v);
		logic [TIMER_WIDTH-1:0] r;
		if (v == 17'd0) begin
			r = TIMER_WIDTH'(1);
		end else if (v > TMAX_EXT) begin
			r = TMAX_EXT[TIMER_WIDTH-1:0];
		end else begin
			r = v[TIMER_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/one_wire_bus_master_unit.sv =====
// Standard-speed 1-Wire bus master driven by one-microsecond tick beats. Every
// input beat (a tick, a command or a no-op) yields exactly one output beat. The
// unit takes one beat per clock cycle while the queue has room, and a beat passes
// the input stage register, the queue and the result register. The slot engine
// sets the rate, retiring one queued beat per cycle unless the output stalls. A
// four-entry queue before the engine keeps input flowing while output waits.
// Write timing registers only while no beat is in flight.
// Depends on owbm_pkg, owbm_front, owbm_queue and owbm_engine.
module one_wire_bus_master_unit import owbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,  // data[7:0], bus_level[8], zero pad
	input  logic [2:0]        s_tuser,  // req_type[2:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	// drive_low[0], busy_res[1], done_res[2], result_value[10:3], rejected[11], pad
	output logic [15:0]       m_tdata
);

	logic           push;
	item_t          push_item;
	logic           pop;
	logic           q_valid;
	item_t          q_item;
	logic           q_full;
	logic [QCW-1:0] q_count;
	result_t        result;

	owbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	owbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_full    (q_full),
		.q_count   (q_count)
	);

	owbm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result    (result)
	);

	assign m_tdata = {4'd0, result.rejected, result.result_value, result.done_res,
	                  result.busy_res, result.drive_low};

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCW'(QDEPTH))
		else $error("queue count beyond its depth");

	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result.done_res |-> !result.busy_res && !result.drive_low &&
		!result.rejected)
		else $error("completed command left the bus held or busy");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !m_tvalid |=> m_tvalid)
		else $error("queued beat not taken by an idle engine");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into a full queue");

endmodule

// ===== hw/rtl/owbm_front.sv =====
// Input stage: takes a beat, sorts it into tick, command or no-op and holds it
// until the queue has room. Depends on owbm_pkg.
module owbm_front import owbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data[7:0], bus_level[8], zero pad
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	input  logic        q_full,
	output logic        push,
	output item_t       push_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;

	always_comb begin
		item_in.req_type  = s_tuser;
		item_in.data      = s_tdata[7:0];
		item_in.bus_level = s_tdata[8];
		if (s_tuser == OP_IDLE) begin
			item_in.kind = KIND_TICK;
		end else if (s_tuser <= OP_RBYTE) begin
			item_in.kind = KIND_CMD;
		end else begin
			item_in.kind = KIND_NOP;
		end
	end

	assign push      = valid_s1 && !q_full;
	assign s_tready  = !valid_s1 || !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== hw/rtl/owbm_queue.sv =====
// Short first-in first-out queue of classified items between front and engine.
// Depends on owbm_pkg.
module owbm_queue import owbm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  item_t          push_item,
	input  logic           pop,
	output logic           q_valid,
	output item_t          q_item,
	output logic           q_full,
	output logic [QCW-1:0] q_count
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign q_valid = count_q != '0;
	assign q_full  = count_q == QCW'(QDEPTH);
	assign q_item  = mem_q[rd_ptr_q];
	assign q_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/owbm_engine.sv =====
// Slot engine: timing registers, the command state and the result register.
// Carries out one queued item per cycle unless the output stalls. Depends on owbm_pkg.
module owbm_engine import owbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output result_t           result
);

	logic [9:0] reset_low_q;
	logic [7:0] presence_wait_q;
	logic [9:0] reset_tail_q;
	logic [7:0] short_low_q;
	logic [7:0] write_zero_q;
	logic [7:0] write_slot_q;
	logic [7:0] read_wait_q;
	logic [7:0] read_tail_q;

	logic [2:0]             op_q;
	logic [1:0]             ph_q;
	logic [TIMER_WIDTH-1:0] tmr_q;
	logic [7:0]             sh_q;
	logic [3:0]             bits_q;
	logic                   line_q;
	logic                   out_valid_q;
	result_t                result_q;

	logic [2:0]             op_n;
	logic [1:0]             ph_n;
	logic [TIMER_WIDTH-1:0] tmr_n;
	logic [TIMER_WIDTH-1:0] tmr_dec;
	logic [7:0]             sh_n;
	logic [3:0]             bits_n;
	logic                   line_n;
	logic                   start;
	logic                   done;
	logic                   rej;
	logic [7:0]             val;
	logic                   cur_write;
	logic                   new_write;
	logic [7:0]             wlo;
	logic [7:0]             wtail;
	logic [9:0]             start_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= 10'd480;
			presence_wait_q <= 8'd70;
			reset_tail_q    <= 10'd410;
			short_low_q     <= 8'd6;
			write_zero_q    <= 8'd60;
			write_slot_q    <= 8'd70;
			read_wait_q     <= 8'd10;
			read_tail_q     <= 8'd55;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RESET_LOW:     reset_low_q     <= cfg_wdata;
				REG_PRESENCE_WAIT: presence_wait_q <= cfg_wdata[7:0];
				REG_RESET_TAIL:    reset_tail_q    <= cfg_wdata;
				REG_SHORT_LOW:     short_low_q     <= cfg_wdata[7:0];
				REG_WRITE_ZERO:    write_zero_q    <= cfg_wdata[7:0];
				REG_WRITE_SLOT:    write_slot_q    <= cfg_wdata[7:0];
				REG_READ_WAIT:     read_wait_q     <= cfg_wdata[7:0];
				REG_READ_TAIL:     read_tail_q     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign pop      = q_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign result   = result_q;

	assign cur_write = (op_q == OP_WBIT) || (op_q == OP_WBYTE);
	assign wlo       = sh_q[0] ? short_low_q : write_zero_q;
	assign wtail     = (write_slot_q > wlo) ? (write_slot_q - wlo) : 8'd1;
	assign tmr_dec   = tmr_q - TIMER_WIDTH'(1);

	always_comb begin
		op_n   = op_q;
		ph_n   = ph_q;
		tmr_n  = tmr_q;
		sh_n   = sh_q;
		bits_n = bits_q;
		line_n = line_q;
		start  = 1'b0;
		done   = 1'b0;
		rej    = 1'b0;
		val    = 8'd0;

		if (q_item.kind == KIND_CMD) begin
			if (op_q != OP_IDLE) begin
				rej = 1'b1;
			end else begin
				op_n   = q_item.req_type;
				sh_n   = (q_item.req_type == OP_WBIT || q_item.req_type == OP_WBYTE) ?
				         q_item.data : 8'd0;
				bits_n = (q_item.req_type == OP_WBYTE || q_item.req_type == OP_RBYTE) ?
				         4'd8 : 4'd1;
				start  = 1'b1;
			end
		end else if (q_item.kind == KIND_TICK && op_q != OP_IDLE) begin
			tmr_n = tmr_dec;
			if (tmr_dec == '0) begin
				case (ph_q)
					PH_LOW: begin
						line_n = 1'b0;
						if (op_q == OP_RESET) begin
							ph_n  = PH_WAIT;
							tmr_n = clamp_len(17'(presence_wait_q));
						end else if (cur_write) begin
							ph_n  = PH_TAIL;
							tmr_n = clamp_len(17'(wtail));
						end else begin
							ph_n  = PH_WAIT;
							tmr_n = clamp_len(17'(read_wait_q));
						end
					end
					PH_WAIT: begin
						ph_n = PH_TAIL;
						if (op_q == OP_RESET) begin
							sh_n  = {7'd0, ~q_item.bus_level};
							tmr_n = clamp_len(17'(reset_tail_q));
						end else begin
							sh_n  = {q_item.bus_level, sh_q[7:1]};
							tmr_n = clamp_len(17'(read_tail_q));
						end
					end
					default: begin
						bits_n = bits_q - 4'd1;
						if (op_q == OP_RESET) begin
							val = {7'd0, sh_q[0]};
						end else if (cur_write) begin
							sh_n = {1'b0, sh_q[7:1]};
						end else if (op_q == OP_RBIT) begin
							val = {7'd0, sh_q[7]};
						end else begin
							val = sh_q;
						end
						if (op_q != OP_RESET && bits_n != 4'd0) begin
							val   = 8'd0;
							start = 1'b1;
						end else begin
							done   = 1'b1;
							op_n   = OP_IDLE;
							ph_n   = PH_IDLE;
							tmr_n  = '0;
							bits_n = 4'd0;
							line_n = 1'b0;
						end
					end
				endcase
			end
		end

		// A new slot takes its low time from the operation and the bit it sends.
		new_write = (op_n == OP_WBIT) || (op_n == OP_WBYTE);
		if (op_n == OP_RESET) begin
			start_len = reset_low_q;
		end else if (new_write) begin
			start_len = {2'd0, sh_n[0] ? short_low_q : write_zero_q};
		end else begin
			start_len = {2'd0, short_low_q};
		end
		if (start) begin
			line_n = 1'b1;
			ph_n   = PH_LOW;
			tmr_n  = clamp_len(17'(start_len));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_IDLE;
			ph_q        <= PH_IDLE;
			tmr_q       <= '0;
			sh_q        <= 8'd0;
			bits_q      <= 4'd0;
			line_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				op_q        <= op_n;
				ph_q        <= ph_n;
				tmr_q       <= tmr_n;
				sh_q        <= sh_n;
				bits_q      <= bits_n;
				line_q      <= line_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.drive_low    <= line_n;
			result_q.busy_res     <= op_n != OP_IDLE;
			result_q.done_res     <= done;
			result_q.result_value <= done ? val : 8'd0;
			result_q.rejected     <= rej;
		end
	end

endmodule
